@@ design/stack_with_insert_under_top_assert.svh @@
// Assertion macros for the stack block. They sample on clk_i, and STK_ASSERT uses rst_ni.
`ifndef STACK_WITH_INSERT_UNDER_TOP_ASSERT_SVH
`define STACK_WITH_INSERT_UNDER_TOP_ASSERT_SVH

// Checked only while the block is out of reset.
`define STK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define STK_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ design/stkins_pkg.sv @@
`default_nettype none

package stkins_pkg;

  // Fixed field widths of the request and result items.
  localparam int CMD_W       = 3;
  localparam int VALUE_W     = 32;
  localparam int DATA_W      = 32;
  localparam int POS_W       = 5;
  localparam int STATUS_W    = 2;
  localparam int FILL_W      = 5;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_POP    = 3'd2,
    CMD_PEEK   = 3'd3,
    CMD_SEARCH = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MOVE,
    ST_PUT,
    ST_SEARCH,
    ST_RESP
  } state_e;

endpackage

`default_nettype wire

@@ design/stack_with_insert_under_top.sv @@
// Channel   Dir  Bits  Contents (lowest bit first)
// s_axis    in   40    cmd[2:0], value[34:3], zero pad[39:35]
// m_axis    out  48    data[31:0], found[32], position[37:33], status[39:38],
//                      fill[44:40], zero pad[47:45]
//
// A request is taken only while the sequencer is idle, even if a result is
// still waiting in the output register. A search reads the stored words from
// the top down, since the single read port of the entry memory fetches one
// stored word per cycle for the shared comparator. Refused and empty-stack
// requests and unused codes go straight to the result. The sequencer returns
// to idle, ready for the next request, as the result is loaded. Reset clears
// the fill count, the sequencer and the output valid; the entry memory is not
// cleared, and no clearing pass is needed. A stalled output holds the finished
// result in the sequencer until the output register is free.
`default_nettype none
`include "stack_with_insert_under_top_assert.svh"

module stack_with_insert_under_top #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // cmd, value, pad
  input  wire logic [stkins_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  // data, found, position, status, fill, pad
  output logic [stkins_pkg::OUT_TDATA_W-1:0]      m_axis_tdata_o
);
  import stkins_pkg::*;

  // Address and count widths follow the depth; the count must hold DEPTH itself.
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int ExtW = (WORD_BITS > DATA_W) ? WORD_BITS : DATA_W;
  localparam int PadW = (CW > POS_W) ? CW : POS_W;

  // Entry memory, index 0 at the bottom of the stack.
  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rdata_q;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;

  state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] rd_ptr_q, rd_ptr_d;
  logic          cmp_vld_q, cmp_vld_d;
  logic [CW-1:0] cmp_pos_q;
  logic          m_valid_q, m_valid_d;
  logic [OUT_TDATA_W-1:0] m_tdata_q;

  // Request held for the whole operation, and the result under construction.
  cmd_e                 cmd_q;
  logic [WORD_BITS-1:0] val_q;
  logic [WORD_BITS-1:0] res_data_q;
  logic                 res_found_q;
  logic [CW-1:0]        res_pos_q;
  status_e              res_status_q;

  logic                 in_fire;
  cmd_e                 in_cmd;
  logic [ExtW-1:0]      in_ext;
  logic [WORD_BITS-1:0] in_word;
  logic                 is_full;
  logic                 is_empty;
  logic [CW-1:0]        top_idx;
  logic [CW-1:0]        scan_idx;
  logic                 scan_issue;
  logic                 search_match;
  logic                 search_done;
  logic                 out_free;
  logic                 out_load;
  logic [ExtW-1:0]      data_ext;
  logic [PadW-1:0]      pos_ext;
  logic [PadW-1:0]      fill_ext;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign in_cmd   = cmd_e'(s_axis_tdata_i[CMD_W-1:0]);
  assign in_ext   = ExtW'(s_axis_tdata_i[CMD_W +: VALUE_W]);
  assign in_word  = in_ext[WORD_BITS-1:0];

  assign is_full  = (count_q == CW'(DEPTH));
  assign is_empty = (count_q == '0);
  assign top_idx  = count_q - CW'(1);
  assign scan_idx = top_idx - rd_ptr_q;

  // The shared comparator looks at the word fetched in the previous cycle.
  assign scan_issue   = (rd_ptr_q < count_q);
  assign search_match = cmp_vld_q && (rdata_q == val_q);
  assign search_done  = search_match || (cmp_vld_q && (cmp_pos_q == count_q));

  assign out_free = !m_valid_q || m_axis_tready_i;
  assign out_load = (state_q == ST_RESP) && out_free;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_cmd)
            CMD_PUSH:   state_d = ST_RESP;
            CMD_INSERT: state_d = (is_full || is_empty) ? ST_RESP : ST_MOVE;
            CMD_POP:    state_d = is_empty ? ST_RESP : ST_READ;
            CMD_PEEK:   state_d = is_empty ? ST_RESP : ST_READ;
            CMD_SEARCH: state_d = is_empty ? ST_RESP : ST_SEARCH;
            default:    state_d = ST_RESP;
          endcase
        end
      end
      ST_READ:   state_d = ST_RESP;
      ST_MOVE:   state_d = ST_PUT;
      ST_PUT:    state_d = ST_RESP;
      ST_SEARCH: begin
        if (search_done) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Memory port control per state.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count_q[AW-1:0];
    mem_wdata = in_word;
    mem_re    = 1'b0;
    mem_raddr = top_idx[AW-1:0];
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_cmd)
            CMD_PUSH:   mem_we = !is_full;
            CMD_INSERT: begin
              // Insert on an empty stack is a plain push.
              mem_we = is_empty;
              mem_re = !is_empty && !is_full;
            end
            CMD_POP:    mem_re = !is_empty;
            CMD_PEEK:   mem_re = !is_empty;
            default:    mem_re = 1'b0;
          endcase
        end
      end
      ST_MOVE: begin
        // The old top moves up one slot.
        mem_we    = 1'b1;
        mem_wdata = rdata_q;
      end
      ST_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = top_idx[AW-1:0];
        mem_wdata = val_q;
      end
      ST_SEARCH: begin
        mem_re    = scan_issue;
        mem_raddr = scan_idx[AW-1:0];
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Control register next values.
  always_comb begin
    count_d   = count_q;
    rd_ptr_d  = rd_ptr_q;
    cmp_vld_d = cmp_vld_q;
    m_valid_d = m_valid_q;
    case (state_q)
      ST_IDLE: begin
        rd_ptr_d  = '0;
        cmp_vld_d = 1'b0;
        if (in_fire && !is_full) begin
          if (in_cmd == CMD_PUSH || (in_cmd == CMD_INSERT && is_empty)) begin
            count_d = count_q + CW'(1);
          end
        end
      end
      ST_READ: begin
        if (cmd_q == CMD_POP) begin
          count_d = count_q - CW'(1);
        end
      end
      ST_PUT: count_d = count_q + CW'(1);
      ST_SEARCH: begin
        rd_ptr_d  = scan_issue ? (rd_ptr_q + CW'(1)) : rd_ptr_q;
        cmp_vld_d = scan_issue;
      end
      default: begin
        count_d = count_q;
      end
    endcase
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      rd_ptr_q  <= '0;
      cmp_vld_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      rd_ptr_q  <= rd_ptr_d;
      cmp_vld_q <= cmp_vld_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  // Payload registers of the operation in flight.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q       <= in_cmd;
      val_q       <= in_word;
      res_data_q  <= '0;
      res_found_q <= 1'b0;
      res_pos_q   <= '0;
      if ((in_cmd == CMD_PUSH || in_cmd == CMD_INSERT) && is_full) begin
        res_status_q <= STATUS_FULL;
      end else if ((in_cmd == CMD_POP || in_cmd == CMD_PEEK) && is_empty) begin
        res_status_q <= STATUS_EMPTY;
      end else begin
        res_status_q <= STATUS_OK;
      end
    end
    if (state_q == ST_READ) begin
      res_data_q <= rdata_q;
    end
    if (state_q == ST_SEARCH) begin
      cmp_pos_q <= rd_ptr_q + CW'(1);
      if (search_match) begin
        res_found_q <= 1'b1;
        res_pos_q   <= cmp_pos_q;
      end
    end
    if (out_load) begin
      m_tdata_q <= {3'b000, fill_ext[FILL_W-1:0], res_status_q, pos_ext[POS_W-1:0],
                    res_found_q, data_ext[DATA_W-1:0]};
    end
  end

  assign data_ext = ExtW'(res_data_q);
  assign pos_ext  = PadW'(res_pos_q);
  assign fill_ext = PadW'(count_q);

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_tdata_q;

  `STK_ASSERT_ALWAYS(a_count_bound, !rst_ni || (count_q <= CW'(DEPTH)), "fill count above depth")
  `STK_ASSERT(a_count_step,
              (count_q == $past(count_q)) || (count_q == $past(count_q) + CW'(1)) ||
              (count_q + CW'(1) == $past(count_q)),
              "fill count moved by more than one")
  `STK_ASSERT(a_full_refused, (out_load && res_status_q == STATUS_FULL) |-> is_full, "full status with room left")
  `STK_ASSERT(a_found_pos, (out_load && res_found_q) |-> (res_pos_q != '0 && res_pos_q <= count_q), "search hit outside the stored entries")

endmodule

`default_nettype wire
